>>> rtl/charlieplex_pwm_led_animator_unit_macros.svh
// Assertion macros for the charlieplexed LED scanner.
// Included by the top level; depends on nothing else.
`ifndef CHARLIEPLEX_PWM_LED_ANIMATOR_UNIT_MACROS_SVH
`define CHARLIEPLEX_PWM_LED_ANIMATOR_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define CPLX_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CPLX_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `CPLX_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define CPLX_ASSERT(lbl, clk, rstn, prop, msg)
`define CPLX_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> rtl/cplx_pwm_pkg.sv
// Shared types and constants of the charlieplexed LED scanner.
// Depends on nothing.
`default_nettype none
package cplx_pwm_pkg;

  localparam int unsigned NUM_LEDS = 12;
  localparam int unsigned NUM_COLS = 4;
  localparam int unsigned LEDS_PER_COL = 3;

  localparam logic [7:0] ANIM_PERIOD_RST = 8'd63;
  localparam logic [3:0] BRIGHT_RST = 4'd5;
  localparam logic [3:0] PTR_RST = 4'd1;
  localparam logic [3:0] PTR_LAST = 4'd11;
  localparam logic [2:0] LEVEL_MAX = 3'd7;

  typedef enum logic [1:0] {
    MODE_FILL   = 2'd0,
    MODE_IDLE_A = 2'd1,
    MODE_SCROLL = 2'd2,
    MODE_IDLE_B = 2'd3
  } mode_e;

  // Fixed walk order of the animation through the LEDs.
  function automatic logic [3:0] led_seq(input logic [3:0] pos);
    logic [3:0] led;
    case (pos)
      4'd0:    led = 4'd3;
      4'd1:    led = 4'd8;
      4'd2:    led = 4'd2;
      4'd3:    led = 4'd7;
      4'd4:    led = 4'd9;
      4'd5:    led = 4'd4;
      4'd6:    led = 4'd5;
      4'd7:    led = 4'd1;
      4'd8:    led = 4'd0;
      4'd9:    led = 4'd6;
      4'd10:   led = 4'd11;
      4'd11:   led = 4'd10;
      default: led = 4'd0;
    endcase
    return led;
  endfunction

endpackage
`default_nettype wire

>>> rtl/charlieplex_pwm_led_animator_unit.sv
// Top level of the charlieplexed LED PWM scanner with touch-selected animation.
// Depends on cplx_pwm_pkg and charlieplex_pwm_led_animator_unit_macros.svh.
`default_nettype none
`include "charlieplex_pwm_led_animator_unit_macros.svh"

// One input word is one timer tick carrying the touch pin sample, and it yields
// exactly one output word with the four pin directions, pin levels and the mode.
// The whole tick update is done in the cycle the word is accepted, so a new word
// is taken every cycle while in_stall_o is low. A two-entry output stage (result
// register plus skid register) lets one more word in while a result waits;
// in_stall_o rises only when both entries are full. The animation period
// register may be written at any time the block is idle and takes effect at once.
module charlieplex_pwm_led_animator_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       touch_pin_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [3:0]      pin_drive_enable_o,
  output logic [3:0]      pin_level_o,
  output logic [1:0]      current_mode_o
);
  import cplx_pwm_pkg::*;

  typedef struct packed {
    logic [3:0] drive_en;
    logic [3:0] level;
    logic [1:0] mode;
  } result_t;

  // Scanner and animation state.
  logic [7:0] anim_period_q;
  logic [2:0] lvl_q [NUM_LEDS];
  logic [2:0] lvl_d [NUM_LEDS];
  logic [2:0] ramp_q, ramp_d;
  logic [1:0] col_q, col_d;
  logic [3:0] onehot_q, onehot_d;
  logic [2:0] lit_q, lit_d;
  logic [7:0] tick_q, tick_d;
  mode_e      mode_q, mode_d;
  logic [3:0] bright_q, bright_d;
  logic [3:0] ptr_q, ptr_d;
  logic       armed_q, armed_d;
  logic       up_q, up_d;

  // Output stage.
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  result_t res;
  logic    accept, out_take;

  logic                touch_fire;
  logic [NUM_LEDS-1:0] lvl_hit;
  logic [2:0]          col_hit;
  logic [3:0]          mask, lit4, drive;
  logic                anim_fire;
  logic                wr_en;
  logic [3:0]          wr_led;
  logic [2:0]          wr_val;
  logic [3:0]          b_inc, b_dec, p_inc, p_dec;
  logic [7:0]          tick_inc;

  assign accept   = in_valid_i && !skid_valid_q;
  assign out_take = out_valid_q && !out_stall_i;

  always_comb begin
    // Touch handling.
    touch_fire = touch_pin_i && armed_q;
    armed_d    = armed_q;
    mode_d     = mode_q;
    bright_d   = bright_q;
    ptr_d      = ptr_q;
    up_d       = up_q;
    if (touch_fire) begin
      armed_d  = 1'b0;
      mode_d   = mode_e'(mode_q + 2'd1);
      bright_d = 4'd0;
      ptr_d    = 4'd0;
      up_d     = 1'b1;
    end else if (!touch_pin_i && !armed_q) begin
      armed_d = 1'b1;
    end

    // PWM scan step; the column moves on when the ramp wraps.
    ramp_d   = ramp_q + 3'd1;
    col_d    = col_q;
    onehot_d = onehot_q;
    lit_d    = lit_q;
    if (ramp_d == 3'd0) begin
      lit_d    = LEVEL_MAX;
      col_d    = col_q + 2'd1;
      onehot_d = 4'b0001 << col_d;
    end
    // Each LED compares its own level; the column then picks three of them.
    for (int k = 0; k < NUM_LEDS; k++) begin
      lvl_hit[k] = ((touch_fire ? 3'd0 : lvl_q[k]) == ramp_d);
    end
    case (col_d)
      2'd0:    col_hit = lvl_hit[2:0];
      2'd1:    col_hit = lvl_hit[5:3];
      2'd2:    col_hit = lvl_hit[8:6];
      default: col_hit = lvl_hit[11:9];
    endcase
    lit_d = lit_d & ~col_hit;

    // Lit bits skip over the driven column pin.
    mask  = onehot_d - 4'd1;
    lit4  = {1'b0, lit_d};
    drive = (lit4 & mask) | ((lit4 & ~mask) << 1);
    res.drive_en = drive | onehot_d;
    res.level    = drive;
    res.mode     = mode_d;

    // Animation timer and step.
    tick_inc  = tick_q + 8'd1;
    anim_fire = (tick_inc == anim_period_q);
    tick_d    = anim_fire ? 8'd0 : tick_inc;

    b_inc  = bright_d + 4'd1;
    b_dec  = bright_d - 4'd1;
    p_inc  = ptr_d + 4'd1;
    p_dec  = ptr_d - 4'd1;
    wr_val = bright_d[2:0];
    wr_led = led_seq(ptr_d);
    wr_en  = 1'b0;
    if (anim_fire) begin
      case (mode_d)
        MODE_SCROLL: begin
          wr_en = 1'b1;
          if (up_d) begin
            if (b_inc > 4'd7) begin
              bright_d = 4'd0;
              ptr_d    = p_inc;
              if (p_inc > PTR_LAST) begin
                ptr_d    = PTR_LAST;
                bright_d = 4'd7;
                up_d     = 1'b0;
              end
            end else begin
              bright_d = b_inc;
            end
          end else begin
            if (b_dec == 4'd0) begin
              bright_d = 4'd7;
              ptr_d    = p_dec;
              if (p_dec == 4'd0) begin
                bright_d = 4'd0;
                up_d     = 1'b1;
              end
            end else begin
              bright_d = b_dec;
            end
          end
        end
        MODE_FILL: begin
          wr_en    = 1'b1;
          bright_d = {1'b0, b_inc[2:0]};
          if (b_inc[2:0] == 3'd0) begin
            ptr_d = (p_inc > PTR_LAST) ? 4'd0 : p_inc;
          end
        end
        default: ;
      endcase
    end
    if (ptr_q > PTR_LAST && !touch_fire) begin
      wr_en = 1'b0;
    end

    for (int k = 0; k < NUM_LEDS; k++) begin
      if (wr_en && wr_led == 4'(k)) begin
        lvl_d[k] = wr_val;
      end else begin
        lvl_d[k] = touch_fire ? 3'd0 : lvl_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anim_period_q <= ANIM_PERIOD_RST;
    end else if (cfg_we_i) begin
      anim_period_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_LEDS; k++) begin
        lvl_q[k] <= 3'd0;
      end
      ramp_q   <= 3'd0;
      col_q    <= 2'd0;
      onehot_q <= 4'd0;
      lit_q    <= 3'd0;
      tick_q   <= 8'd1;
      mode_q   <= MODE_FILL;
      bright_q <= BRIGHT_RST;
      ptr_q    <= PTR_RST;
      armed_q  <= 1'b0;
      up_q     <= 1'b0;
    end else if (accept) begin
      lvl_q    <= lvl_d;
      ramp_q   <= ramp_d;
      col_q    <= col_d;
      onehot_q <= onehot_d;
      lit_q    <= lit_d;
      tick_q   <= tick_d;
      mode_q   <= mode_d;
      bright_q <= bright_d;
      ptr_q    <= ptr_d;
      armed_q  <= armed_d;
      up_q     <= up_d;
    end
  end

  // The skid register fills only while the result register is held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_q || accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign in_stall_o         = skid_valid_q;
  assign out_valid_o        = out_valid_q;
  assign pin_drive_enable_o = out_q.drive_en;
  assign pin_level_o        = out_q.level;
  assign current_mode_o     = out_q.mode;

  `CPLX_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q, "skid word without result word")
  `CPLX_ASSERT_NEVER(a_bright_range, clk_i, rst_ni, bright_q > 4'd7, "brightness above maximum level")
  `CPLX_ASSERT_NEVER(a_ptr_range, clk_i, rst_ni, ptr_q > PTR_LAST, "LED pointer past last LED")
  `CPLX_ASSERT(a_level_driven, clk_i, rst_ni, out_valid_q |-> ((out_q.level & ~out_q.drive_en) == 4'd0), "high level on undriven pin")

endmodule
`default_nettype wire

>>> tb/tb_charlieplex_pwm_led_animator_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the charlieplexed LED PWM scanner with touch-selected animation.
// Drives touch ticks through a valid/stall channel, checks each pin word against its predictor
// of scan and animation or a fixed row. Depends on cplx_pwm_pkg and the top-level RTL only.
module tb_charlieplex_pwm_led_animator_unit;
  import cplx_pwm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_WORDS = 320;
  localparam int unsigned DIR_ROWS = 24;
  // Animation walk order, position 0 in the low nibble.
  localparam logic [47:0] WALK_ORDER = {4'd10, 4'd11, 4'd6, 4'd0, 4'd1, 4'd5,
                                        4'd4, 4'd9, 4'd7, 4'd2, 4'd8, 4'd3};

  typedef struct packed {
    logic [3:0] drive_en;
    logic [3:0] level;
    mode_e      mode;
  } pins_t;

  typedef struct packed {
    logic  touch;
    logic  fixed;
    pins_t want;
  } row_t;

  localparam pins_t UNTYPED = '0;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       touch_pin_i = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [3:0] pin_drive_enable_o;
  logic [3:0] pin_level_o;
  logic [1:0] current_mode_o;

  // A typed-in expectation travels with its word and replaces the predicted one.
  logic  fixed_due = 1'b0;
  pins_t fixed_pins = '0;

  // Predictor state.
  logic [7:0] period_m;
  logic [2:0] lvl_m [NUM_LEDS];
  logic [2:0] ramp_m;
  logic [1:0] col_m;
  logic [3:0] col_hot_m;
  logic [2:0] lit_m;
  logic [7:0] tick_m;
  mode_e      mode_m;
  logic [3:0] bright_m;
  logic [3:0] ptr_m;
  logic       armed_m;
  logic       up_m;

  pins_t       pins_due[$];
  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_bad = 0;
  int unsigned n_cycles = 0;
  int unsigned n_holds = 0;
  int unsigned stall_hits = 0;
  logic [3:0]  modes_seen = '0;

  charlieplex_pwm_led_animator_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .touch_pin_i        (touch_pin_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pin_drive_enable_o (pin_drive_enable_o),
    .pin_level_o        (pin_level_o),
    .current_mode_o     (current_mode_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", n_cycles,
               pins_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // One timer tick: touch handling, one PWM scan step, then a possible animation step.
  function automatic pins_t scan_tick(input logic touch);
    logic [7:0] mask;
    logic [7:0] lit8;
    logic [7:0] drive;
    logic [1:0] next_mode;
    pins_t      res;
    if (touch && armed_m) begin
      armed_m = 1'b0;
      next_mode = mode_m + 2'd1;
      mode_m = mode_e'(next_mode);
      bright_m = '0;
      up_m = 1'b1;
      ptr_m = '0;
      for (int i = 0; i < NUM_LEDS; i++) lvl_m[i] = '0;
    end else if (!touch && !armed_m) begin
      armed_m = 1'b1;
    end

    ramp_m = ramp_m + 3'd1;
    if (ramp_m == 3'd0) begin
      lit_m = LEVEL_MAX;
      col_m = col_m + 2'd1;
      col_hot_m = 4'b0001 << col_m;
    end
    for (int i = 0; i < LEDS_PER_COL; i++) begin
      if (lvl_m[int'(col_m) * LEDS_PER_COL + i] == ramp_m) lit_m[i] = 1'b0;
    end
    // Pins below the column pin take the lit bits as they are, the rest shift up past it.
    mask = {4'b0000, col_hot_m} - 8'd1;
    lit8 = {5'b00000, lit_m};
    drive = (lit8 & mask) | ((lit8 & ~mask) << 1);
    res.drive_en = drive[3:0] | col_hot_m;
    res.level = drive[3:0];
    res.mode = mode_m;

    tick_m = tick_m + 8'd1;
    if (tick_m == period_m) begin
      tick_m = '0;
      if ((mode_m == MODE_SCROLL || mode_m == MODE_FILL) && ptr_m <= PTR_LAST) begin
        lvl_m[WALK_ORDER[4 * ptr_m +: 4]] = bright_m[2:0];
      end
      if (mode_m == MODE_SCROLL && up_m) begin
        bright_m = bright_m + 4'd1;
        if (bright_m > 4'd7) begin
          bright_m = '0;
          ptr_m = ptr_m + 4'd1;
          if (ptr_m > PTR_LAST) begin
            ptr_m = PTR_LAST;
            bright_m = {1'b0, LEVEL_MAX};
            up_m = 1'b0;
          end
        end
      end else if (mode_m == MODE_SCROLL) begin
        bright_m = bright_m - 4'd1;
        if (bright_m == '0) begin
          bright_m = {1'b0, LEVEL_MAX};
          ptr_m = ptr_m - 4'd1;
          if (ptr_m == '0) begin
            bright_m = '0;
            up_m = 1'b1;
          end
        end
      end else if (mode_m == MODE_FILL) begin
        bright_m = {1'b0, bright_m[2:0] + 3'd1};
        if (bright_m == '0) begin
          ptr_m = ptr_m + 4'd1;
          if (ptr_m > PTR_LAST) ptr_m = '0;
        end
      end
    end
    modes_seen[mode_m] = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input pins_t want, input pins_t got);
    n_bad++;
    if (n_bad <= 10) begin
      $display("%0t: %s: expected drive %b level %b mode %0d, got drive %b level %b mode %0d",
               $time, what, want.drive_en, want.level, want.mode,
               got.drive_en, got.level, got.mode);
    end
  endtask

  // Output check comes before the input side so that a stray word is never matched
  // against an expectation pushed at the same edge.
  always @(posedge clk_i) begin
    pins_t got;
    pins_t want;
    pins_t model;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        got = '{pin_drive_enable_o, pin_level_o, mode_e'(current_mode_o)};
        n_out++;
        if (pins_due.size() == 0) begin
          report_mismatch("word with no result due", UNTYPED, got);
        end else begin
          want = pins_due.pop_front();
          if (got !== want) report_mismatch("pin word mismatch", want, got);
        end
      end
      if (in_valid_i && in_stall_o === 1'b0) begin
        model = scan_tick(touch_pin_i);
        pins_due.push_back(fixed_due ? fixed_pins : model);
        n_in++;
      end
      if (in_valid_i && in_stall_o === 1'b1) stall_hits++;
    end
  end

  task automatic offer_word(input logic touch, input logic fixed, input pins_t want);
    in_valid_i <= 1'b1;
    touch_pin_i <= touch;
    fixed_due <= fixed;
    fixed_pins <= want;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
  endtask

  task automatic set_period(input logic [7:0] value);
    in_valid_i <= 1'b0;
    // A clock edge lets the checker record the last accepted word before the queue is read.
    @(posedge clk_i);
    while (pins_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    period_m = value;
  endtask

  // Receiver: changing stall patterns, plus two long hold-offs that fill the block.
  initial begin
    int unsigned mode_left;
    int unsigned pattern;
    mode_left = 0;
    pattern = 0;
    @(posedge rst_ni);
    forever begin
      if ((n_holds == 0 && n_in >= 400) || (n_holds == 1 && n_in >= 1100)) begin
        n_holds++;
        out_stall_i <= 1'b1;
        repeat (150) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        pattern = $urandom_range(0, 3);
        mode_left = $urandom_range(30, 200);
      end
      mode_left--;
      case (pattern)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= mode_left[2];
      endcase
      @(posedge clk_i);
    end
  end

  initial begin
    row_t        dir_rows [DIR_ROWS];
    logic [7:0]  phase_period [6];
    int unsigned burst_left;
    int unsigned run_len;
    int unsigned sent;
    logic        level_now;
    logic        noisy;

    // Rows 0-2 leave reset: the ramp has not wrapped yet, so no pin is driven.
    dir_rows = '{
      '{1'b0, 1'b1, '{4'h0, 4'h0, MODE_FILL}},
      '{1'b1, 1'b1, '{4'h0, 4'h0, MODE_IDLE_A}},
      '{1'b1, 1'b1, '{4'h0, 4'h0, MODE_IDLE_A}},
      '{1'b0, 1'b0, UNTYPED}, '{1'b1, 1'b0, UNTYPED},
      '{1'b1, 1'b0, UNTYPED}, '{1'b1, 1'b0, UNTYPED}, '{1'b1, 1'b0, UNTYPED},
      '{1'b1, 1'b0, UNTYPED}, '{1'b1, 1'b0, UNTYPED}, '{1'b1, 1'b0, UNTYPED},
      '{1'b1, 1'b0, UNTYPED}, '{1'b1, 1'b0, UNTYPED},
      '{1'b0, 1'b0, UNTYPED}, '{1'b1, 1'b0, UNTYPED},
      '{1'b0, 1'b0, UNTYPED}, '{1'b1, 1'b0, UNTYPED},
      '{1'b1, 1'b0, UNTYPED}, '{1'b1, 1'b0, UNTYPED}, '{1'b1, 1'b0, UNTYPED},
      '{1'b1, 1'b0, UNTYPED},
      '{1'b0, 1'b0, UNTYPED}, '{1'b0, 1'b0, UNTYPED}, '{1'b0, 1'b0, UNTYPED}
    };
    phase_period = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd0, 8'd2};
    phase_period[4] = 8'($urandom_range(4, 40));

    period_m = ANIM_PERIOD_RST;
    for (int i = 0; i < NUM_LEDS; i++) lvl_m[i] = '0;
    ramp_m = '0;
    col_m = '0;
    col_hot_m = '0;
    lit_m = '0;
    tick_m = 8'd1;
    mode_m = MODE_FILL;
    bright_m = BRIGHT_RST;
    ptr_m = PTR_RST;
    armed_m = 1'b0;
    up_m = 1'b0;
    level_now = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A period of 2 animates on the very first tick and every second one after.
    set_period(8'd2);
    for (int r = 0; r < DIR_ROWS; r++) begin
      offer_word(dir_rows[r].touch, dir_rows[r].fixed, dir_rows[r].want);
    end

    for (int p = 0; p < 6; p++) begin
      set_period(phase_period[p]);
      sent = 0;
      burst_left = 0;
      while (sent < PHASE_WORDS) begin
        // Mostly long steady levels so the animation gets deep; each rising level is a touch.
        noisy = ($urandom_range(0, 9) >= 7);
        if (noisy) begin
          run_len = $urandom_range(1, 8);
        end else begin
          run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(120, 260)
                                                : $urandom_range(10, 80);
          level_now = ~level_now;
        end
        for (int k = 0; k < run_len && sent < PHASE_WORDS; k++) begin
          if (burst_left == 0) begin
            in_valid_i <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk_i);
            burst_left = ($urandom_range(0, 4) == 0) ? 150 : $urandom_range(1, 20);
          end
          offer_word(noisy ? 1'($urandom_range(0, 1)) : level_now, 1'b0, UNTYPED);
          burst_left--;
          sent++;
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pins_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d touch ticks under animation periods 2, 1, 0, 255, 3 and %0d; %0d words checked.",
             n_in, phase_period[4], n_out);
    $display("Modes reached %b, input stalled on %0d cycles, %0d long receiver hold-offs.",
             modes_seen, stall_hits, n_holds);
    if (n_bad == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", n_bad);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cplx_pwm_pkg.sv
rtl/charlieplex_pwm_led_animator_unit.sv
tb/tb_charlieplex_pwm_led_animator_unit.sv
